>>> hdl/assert_macros.svh
// Assertion macros shared by the URL percent decoder modules.
// No dependencies; each file that checks its logic includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define ASSERT_AT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");
// Condition that must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_AT(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, expr)
`endif
`endif

>>> hdl/upd_pkg.sv
// Shared types, constants and hex helpers of the URL percent decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package upd_pkg;

    localparam logic [7:0] PCT_CHAR = 8'h25;

    // Depth of the request queue between the front and the back.
    localparam int UPD_QDEPTH = 4;
    localparam int UPD_QPTR_W = $clog2(UPD_QDEPTH);
    localparam int UPD_QCNT_W = $clog2(UPD_QDEPTH + 1);

    // One queued request: up to three output bytes, lowest slot first.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      cnt;
        logic            last;
    } upd_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } upd_qstat_t;

    function automatic logic is_hex(input logic [7:0] b);
        return (b inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]});
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] v;
        v = 8'h00;
        if (b inside {[8'h30:8'h39]}) begin
            v = b - 8'h30;
        end else if (b inside {[8'h61:8'h66]}) begin
            v = b - 8'h57;
        end else if (b inside {[8'h41:8'h46]}) begin
            v = b - 8'h37;
        end
        return v[3:0];
    endfunction

endpackage

>>> hdl/upd_front.sv
// Front end of the URL percent decoder: tracks the escape state and turns
// each accepted byte into zero to three bytes, queued as one request if any. Uses upd_pkg.
`timescale 1ns / 1ps

module upd_front import upd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  upd_qstat_t q_stat,
    output logic       q_wr,
    output upd_entry_t q_wdata
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PCT,
        PH_DIG
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;
    upd_entry_t ent;
    logic       accept;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        logic [1:0] n;
        logic       hex;
        logic       do_plain;
        n          = 2'd0;
        hex        = is_hex(in_byte);
        do_plain   = 1'b0;
        ent        = '0;
        phase_next = PH_IDLE;
        held_next  = held_reg;
        case (phase_reg)
            PH_PCT: begin
                if (hex) begin
                    held_next  = in_byte;
                    phase_next = PH_DIG;
                end else begin
                    ent.bytes[n] = PCT_CHAR;
                    n = n + 2'd1;
                    do_plain = 1'b1;
                end
            end
            PH_DIG: begin
                if (hex) begin
                    ent.bytes[n] = {hex_val(held_reg), hex_val(in_byte)};
                    n = n + 2'd1;
                end else begin
                    ent.bytes[n] = PCT_CHAR;
                    n = n + 2'd1;
                    ent.bytes[n] = held_reg;
                    n = n + 2'd1;
                    do_plain = 1'b1;
                end
            end
            default: begin
                do_plain = 1'b1;
            end
        endcase
        // The byte that broke an escape is handled as a fresh byte.
        if (do_plain) begin
            if (in_byte == PCT_CHAR) begin
                phase_next = PH_PCT;
            end else begin
                ent.bytes[n] = in_byte;
                n = n + 2'd1;
            end
        end
        // End of string flushes whatever escape is still pending.
        if (in_last) begin
            if (phase_next == PH_PCT) begin
                ent.bytes[n] = PCT_CHAR;
                n = n + 2'd1;
            end else if (phase_next == PH_DIG) begin
                ent.bytes[n] = PCT_CHAR;
                n = n + 2'd1;
                ent.bytes[n] = held_next;
                n = n + 2'd1;
            end
            phase_next = PH_IDLE;
            held_next  = 8'h00;
        end
        ent.cnt  = n;
        ent.last = in_last;
    end

    assign q_wr    = accept && (ent.cnt != 2'd0);
    assign q_wdata = ent;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'h00;
        end else if (accept) begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

>>> hdl/upd_queue.sv
// Small request queue that decouples the decoder front end from the byte
// serializer. Uses upd_pkg for the entry type and depth.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module upd_queue import upd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       wr,
    input  upd_entry_t wdata,
    input  logic       rd,
    output upd_entry_t rdata,
    output upd_qstat_t stat
);

    upd_entry_t            mem [UPD_QDEPTH];
    logic [UPD_QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [UPD_QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [UPD_QCNT_W-1:0] cnt_reg, cnt_next;

    localparam logic [UPD_QPTR_W-1:0] PTR_TOP = UPD_QPTR_W'(UPD_QDEPTH - 1);
    localparam logic [UPD_QCNT_W-1:0] CNT_FULL = UPD_QCNT_W'(UPD_QDEPTH);

    assign stat.full  = (cnt_reg == CNT_FULL);
    assign stat.empty = (cnt_reg == '0);
    assign rdata      = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_TOP) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_TOP) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr && !rd) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (rd && !wr) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    `ASSERT_NEVER(a_q_overflow, aclk, aresetn, wr && stat.full)
    `ASSERT_NEVER(a_q_underflow, aclk, aresetn, rd && stat.empty)
    `ASSERT_AT(a_q_count, aclk, aresetn, (wr && !rd) |=> (cnt_reg == $past(cnt_reg) + 1'b1))

endmodule

>>> hdl/upd_back.sv
// Back end of the URL percent decoder: walks the bytes of the queue head and
// drives the registered result stream. Uses upd_pkg.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module upd_back import upd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  upd_entry_t q_rdata,
    input  upd_qstat_t q_stat,
    output logic       q_rd,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       load;
    logic       final_slot;

    // The output register takes a new byte, if the queue holds one, whenever it is empty or drained.
    assign load       = !valid_reg || out_ready;
    assign final_slot = (idx_reg == q_rdata.cnt - 2'd1);
    assign q_rd       = load && !q_stat.empty && final_slot;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = !q_stat.empty;
            if (!q_stat.empty) begin
                idx_next = final_slot ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && !q_stat.empty) begin
            byte_reg <= q_rdata.bytes[idx_reg];
            last_reg <= q_rdata.last && final_slot;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;

    `ASSERT_AT(a_idx_in_range, aclk, aresetn, !q_stat.empty |-> (idx_reg < q_rdata.cnt))
    `ASSERT_AT(a_idx_idle, aclk, aresetn, q_stat.empty |-> (idx_reg == 2'd0))
    `ASSERT_AT(a_out_hold, aclk, aresetn, (out_valid && !out_ready) |=> (out_valid && $stable(out_byte) && $stable(out_last)))

endmodule

>>> hdl/url_percent_decoder.sv
// Top level of the streaming URL percent decoder.
// Depends on upd_pkg, upd_front, upd_queue and upd_back.
//
// Accepts one raw URL byte per cycle unless the request queue is full and
// emits decoded bytes at up to one per cycle. A '%' and two hex digits of
// either case collapse into one byte; broken or truncated escapes come out
// literally, and s_tlast on the final input byte marks the final output byte
// with m_tlast. Each input byte turns into zero to three output bytes, which
// pass through the request queue and then the output register. The output
// register sustains one byte per cycle while m_tready is high, so a flush of
// two or three literal bytes occupies the output longer than a byte that
// yields a single result. A four-entry request queue between the decoder
// and the serializer absorbs such bursts; s_tready drops only while it is full.
`timescale 1ns / 1ps

module url_percent_decoder import upd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // out_last
);

    upd_qstat_t q_stat;
    upd_entry_t q_wdata;
    upd_entry_t q_rdata;
    logic       q_wr;
    logic       q_rd;

    upd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .q_stat   (q_stat),
        .q_wr     (q_wr),
        .q_wdata  (q_wdata)
    );

    upd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (q_wr),
        .wdata   (q_wdata),
        .rd      (q_rd),
        .rdata   (q_rdata),
        .stat    (q_stat)
    );

    upd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_rdata   (q_rdata),
        .q_stat    (q_stat),
        .q_rd      (q_rd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for url_percent_decoder.
// Depends on upd_pkg and the decoder RTL; streams encoded URL strings with random
// gaps on both sides and checks every decoded byte against a built-in predictor.
`timescale 1ns / 1ps

module tb_top;
    import upd_pkg::*;

    localparam int unsigned STUCK_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned TARGET_BYTES = 330;
    localparam int unsigned MAX_REPORTS = 10;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } esc_phase_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } url_byte_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    url_percent_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    url_byte_t   raw_q[$];       // encoded bytes waiting to be sent
    url_byte_t   decoded_q[$];   // decoded bytes the block still owes us
    url_byte_t   raw_next;

    esc_phase_t  pred_phase = PH_IDLE;
    logic [7:0]  pred_held = 8'h00;

    logic        s_fire = 1'b0;
    bit          src_calm = 1'b0;
    bit          snk_calm = 1'b0;
    int unsigned src_gap = 0;
    int unsigned snk_gap = 0;
    int unsigned stuck_cycles = 0;
    int unsigned err_count = 0;
    int unsigned bytes_in = 0;
    int unsigned bytes_out = 0;
    int unsigned strings_in = 0;
    int unsigned escapes_decoded = 0;
    int unsigned escapes_literal = 0;

    function automatic logic is_hex_char(input logic [7:0] c);
        logic [7:0] folded;
        folded = c | 8'h20;
        return (c >= 8'h30 && c <= 8'h39) || (folded >= 8'h61 && folded <= 8'h66);
    endfunction

    // Valid only for hex characters: letters of both cases carry 1..6 in the low nibble.
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        if (c <= 8'h39) begin
            return c[3:0];
        end
        return c[3:0] + 4'd9;
    endfunction

    // Advances the decoder state by one raw byte and queues the bytes it produces.
    function automatic void decode_raw(input logic [7:0] b, input logic last);
        logic [7:0] outs[$];
        bit         fresh;
        fresh = 1'b1;
        case (pred_phase)
            PH_PCT: begin
                if (is_hex_char(b)) begin
                    pred_held = b;
                    pred_phase = PH_DIGIT;
                    fresh = 1'b0;
                end else begin
                    outs.push_back(PCT_CHAR);
                    escapes_literal++;
                end
            end
            PH_DIGIT: begin
                if (is_hex_char(b)) begin
                    outs.push_back({hex_nibble(pred_held), hex_nibble(b)});
                    pred_phase = PH_IDLE;
                    fresh = 1'b0;
                    escapes_decoded++;
                end else begin
                    outs.push_back(PCT_CHAR);
                    outs.push_back(pred_held);
                    escapes_literal++;
                end
            end
            default: ;
        endcase
        // The byte that broke an escape is handled as a brand new byte.
        if (fresh) begin
            if (b == PCT_CHAR) begin
                pred_phase = PH_PCT;
            end else begin
                pred_phase = PH_IDLE;
                outs.push_back(b);
            end
        end
        if (last) begin
            if (pred_phase == PH_PCT) begin
                outs.push_back(PCT_CHAR);
                escapes_literal++;
            end else if (pred_phase == PH_DIGIT) begin
                outs.push_back(PCT_CHAR);
                outs.push_back(pred_held);
                escapes_literal++;
            end
            pred_phase = PH_IDLE;
            pred_held = 8'h00;
        end
        foreach (outs[i]) begin
            decoded_q.push_back('{data: outs[i], last: last && (i == outs.size() - 1)});
        end
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] rand_hex();
        int unsigned v;
        v = $urandom_range(0, 15);
        if (v < 10) begin
            return 8'(8'h30 + v);
        end
        if ($urandom_range(0, 1) == 0) begin
            return 8'(8'h41 + v - 10);
        end
        return 8'(8'h61 + v - 10);
    endfunction

    // Mostly bytes just outside the hex ranges, plus '%' and arbitrary bytes.
    function automatic logic [7:0] rand_breaker();
        case ($urandom_range(0, 7))
            0: return 8'h2f;
            1: return 8'h3a;
            2: return 8'h40;
            3: return 8'h47;
            4: return 8'h60;
            5: return 8'h67;
            6: return PCT_CHAR;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_raw(input logic [7:0] b, input logic last);
        raw_q.push_back('{data: b, last: last});
        if (last) begin
            strings_in++;
        end
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            add_raw(s[i], i == s.len() - 1);
        end
    endtask

    task automatic add_random_string();
        logic [7:0]  chars[$];
        int unsigned len;
        int unsigned r;
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                chars.push_back(PCT_CHAR);
                chars.push_back(rand_hex());
                chars.push_back(rand_hex());
            end else if (r < 47) begin
                chars.push_back(PCT_CHAR);
                if ($urandom_range(0, 1) == 1) begin
                    chars.push_back(rand_hex());
                end
                chars.push_back(rand_breaker());
            end else begin
                chars.push_back(8'($urandom_range(0, 255)));
            end
        end
        // Some strings stop in the middle of an escape.
        r = $urandom_range(0, 9);
        if (r == 0) begin
            chars.push_back(PCT_CHAR);
        end else if (r == 1) begin
            chars.push_back(PCT_CHAR);
            chars.push_back(rand_hex());
        end
        foreach (chars[i]) begin
            add_raw(chars[i], i == chars.size() - 1);
        end
    endtask

    task automatic report_mismatch(input string what, input url_byte_t want);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("mismatch (%s): expected data %02h last %0b, got data %02h last %0b",
                     what, want.data, want.last, m_tdata, m_tlast);
        end
    endtask

    // Source side: a new request goes out once the previous one was taken.
    always @(negedge aclk) begin
        if (aresetn) begin
            if ($urandom_range(0, 63) == 0) begin
                src_calm = !src_calm;
            end
            if (!s_tvalid || s_fire) begin
                if (src_gap != 0) begin
                    s_tvalid <= 1'b0;
                    src_gap--;
                end else if (raw_q.size() != 0) begin
                    raw_next = raw_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= raw_next.data;
                    s_tlast <= raw_next.last;
                    src_gap = src_calm ? 0 : pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sink side: ready drops for random stretches.
    always @(negedge aclk) begin
        if (aresetn) begin
            if ($urandom_range(0, 63) == 0) begin
                snk_calm = !snk_calm;
            end
            if (snk_gap != 0) begin
                m_tready <= 1'b0;
                snk_gap--;
            end else begin
                m_tready <= 1'b1;
                if (!snk_calm) begin
                    snk_gap = pick_gap();
                end
            end
        end
    end

    always @(posedge aclk) begin
        url_byte_t want;
        if (aresetn) begin
            s_fire <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                bytes_in++;
                decode_raw(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                bytes_out++;
                if (decoded_q.size() == 0) begin
                    want = '{data: 8'h00, last: 1'b0};
                    report_mismatch("unexpected byte", want);
                end else begin
                    want = decoded_q.pop_front();
                    if (m_tdata !== want.data || m_tlast !== want.last) begin
                        report_mismatch("wrong field", want);
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
            end
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles, %0d bytes outstanding",
                         stuck_cycles, decoded_q.size());
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    initial begin
        // Directed strings: byte extremes, both hex cases, broken and cut-off escapes.
        add_raw(8'h00, 1'b0);
        add_raw(8'hff, 1'b1);
        add_text("%4a");
        add_text("%Ff");
        add_text("%00");
        add_text("%zB");
        add_text("%4%41");
        add_text("%");
        add_text("%7");
        add_text("%%");
        while (raw_q.size() < TARGET_BYTES) begin
            add_random_string();
        end

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        while (raw_q.size() != 0 || s_tvalid) begin
            @(posedge aclk);
        end
        while (decoded_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("summary: %0d strings, %0d raw bytes in, %0d decoded bytes out",
                 strings_in, bytes_in, bytes_out);
        $display("summary: %0d escapes decoded, %0d emitted literally, %0d mismatches",
                 escapes_decoded, escapes_literal, err_count);
        if (err_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/upd_pkg.sv
hdl/upd_front.sv
hdl/upd_queue.sv
hdl/upd_back.sv
hdl/url_percent_decoder.sv
tb/tb_top.sv
